@@ hw/rtl/lsfpe_pkg.sv @@
// shared types, constants and the pattern table for the line sensor frame decoder
// no dependencies; imported by lsfpe_ctrl, lsfpe_dp and the top level
package lsfpe_pkg;

   localparam logic [7:0] FRAME_HEADER  = 8'h75;
   localparam logic [7:0] FRAME_TRAILER = 8'h02;
   localparam logic [5:0] GAIN_RESET    = 6'd40;

   localparam int SENSOR_COUNT = 7;
   // dividend magnitude is at most 19, so five restoring steps
   localparam int DIV_STEPS    = 5;

   localparam logic [1:0] POS_HEADER = 2'd0;
   localparam logic [1:0] POS_DATA   = 2'd1;
   localparam logic [1:0] POS_TRAIL  = 2'd2;

   localparam logic signed [4:0] BIT_WEIGHT [SENSOR_COUNT] = '{
      -5'sd10, -5'sd6, -5'sd3, 5'sd0, 5'sd3, 5'sd6, 5'sd10
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_FIX,
      ST_MUL
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic div_step;
      logic fix;
      logic mul;
   } dp_cmd_type;

   typedef struct packed {
      logic last_byte;
      logic frame_ok;
      logic div_skip;
      logic rsp_full;
   } dp_status_type;

   typedef struct packed {
      logic              hit;
      logic signed [4:0] value;
   } pattern_hit_type;

   // known sensor patterns and their raw error
   function automatic pattern_hit_type pattern_lookup(input logic [7:0] bits);
      pattern_hit_type res;
      res.hit = 1'b1;
      case (bits)
         8'h7E:   res.value = -5'sd10;
         8'h7C:   res.value = -5'sd9;
         8'h78:   res.value = -5'sd5;
         8'h79:   res.value = -5'sd4;
         8'h71:   res.value = -5'sd2;
         8'h73:   res.value = -5'sd1;
         8'h63:   res.value = 5'sd0;
         8'h77:   res.value = 5'sd0;
         8'h67:   res.value = 5'sd1;
         8'h47:   res.value = 5'sd2;
         8'h4F:   res.value = 5'sd4;
         8'h0F:   res.value = 5'sd5;
         8'h07:   res.value = 5'sd9;
         8'h03:   res.value = 5'sd10;
         8'h1F:   res.value = 5'sd9;
         8'h3F:   res.value = 5'sd10;
         8'h7F:   res.value = 5'sd0;
         default: begin
            res.hit   = 1'b0;
            res.value = 5'sd0;
         end
      endcase
      return res;
   endfunction

endpackage

@@ hw/rtl/line_sensor_frame_position_error.sv @@
// line sensor frame decoder, top level: one result per valid three-byte frame
// sequence: a table hit or zero error goes from load straight to multiply; otherwise
// the weighted average goes through the 5-step divider and a sign fix first
// throughput: header and data words 1 per cycle while idle; a valid trailer holds
// the input until its result is loaded, and waits unaccepted while an output is pending
// reset (synchronous): byte position to header, gain to 40, output empty
module line_sensor_frame_position_error
   import lsfpe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               csr_wr_en,
   input  logic [5:0]         csr_wr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [10:0] rsp_position_error,
   output logic [7:0]         rsp_line_bits
);

   dp_cmd_type     cmd;
   dp_status_type  status;
   ctrl_state_type state;

   lsfpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   lsfpe_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position_error (rsp_position_error),
      .rsp_line_bits      (rsp_line_bits)
   );

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state != ST_IDLE) |-> req_stall)
      else $error("input not stalled while a frame is in work");

   a_load_into_empty: assert property (@(posedge clock) disable iff (reset)
      (state == ST_MUL) |-> !rsp_valid)
      else $error("result loaded over a pending output word");

   a_rise_from_mul: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state) == ST_MUL))
      else $error("output valid without a multiply step");

   a_error_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position_error >= -11'sd630) && (rsp_position_error <= 11'sd630))
      else $error("position error out of range");

endmodule

@@ hw/rtl/lsfpe_ctrl.sv @@
// controller state machine: byte acceptance, divide sequencing, result load
// depends on lsfpe_pkg
module lsfpe_ctrl
   import lsfpe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  dp_status_type  status,
   output dp_cmd_type     cmd,
   output ctrl_state_type state
);

   ctrl_state_type state_ff, state_in;
   logic [2:0]     step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      // a trailer byte waits until the output word has been taken
      req_stall = (state_ff != ST_IDLE) || (status.last_byte && status.rsp_full);
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid && !req_stall;
            if (cmd.accept && status.last_byte && status.frame_ok) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = status.div_skip ? ST_MUL : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 3'd1;
            if (step_ff == 3'(DIV_STEPS - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

@@ hw/rtl/lsfpe_dp.sv @@
// datapath: frame assembly, pattern table, weighted average divider, gain multiply
// depends on lsfpe_pkg; driven by lsfpe_ctrl commands
module lsfpe_dp
   import lsfpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_rx_byte,
   input  logic                csr_wr_en,
   input  logic [5:0]          csr_wr_data,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [10:0]  rsp_position_error,
   output logic [7:0]          rsp_line_bits
);

   logic [1:0]         pos_ff, pos_in;
   logic [7:0]         header_hold_ff, header_hold_in;
   logic [7:0]         sensor_hold_ff, sensor_hold_in;
   logic [5:0]         gain_ff, gain_in;
   logic signed [4:0]  raw_ff, raw_in;
   logic [4:0]         quot_ff, quot_in;
   logic [2:0]         rem_ff, rem_in;
   logic [2:0]         divisor_ff, divisor_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [10:0] rsp_error_ff, rsp_error_in;
   logic [7:0]         rsp_bits_ff, rsp_bits_in;

   pattern_hit_type    lookup;
   logic signed [5:0]  sum_w;
   logic [2:0]         cnt_w;
   logic [5:0]         sum_abs;
   logic [3:0]         trial;
   logic signed [10:0] product;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HEADER;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      header_hold_ff <= header_hold_in;
      sensor_hold_ff <= sensor_hold_in;
      raw_ff         <= raw_in;
      quot_ff        <= quot_in;
      rem_ff         <= rem_in;
      divisor_ff     <= divisor_in;
      neg_ff         <= neg_in;
      rsp_error_ff   <= rsp_error_in;
      rsp_bits_ff    <= rsp_bits_in;
   end

   // active-low sensor bits: sum of weights and count
   always_comb begin
      sum_w = '0;
      cnt_w = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (!sensor_hold_ff[i]) begin
            sum_w = sum_w + {BIT_WEIGHT[i][4], BIT_WEIGHT[i]};
            cnt_w = cnt_w + 3'd1;
         end
      end
      sum_abs = sum_w[5] ? 6'(-sum_w) : sum_w;
   end

   assign lookup  = pattern_lookup(sensor_hold_ff);
   assign trial   = {rem_ff, quot_ff[4]};
   assign product = 11'(raw_ff) * 11'($signed({1'b0, gain_ff}));

   always_comb begin
      pos_in         = pos_ff;
      header_hold_in = header_hold_ff;
      sensor_hold_in = sensor_hold_ff;
      gain_in        = csr_wr_en ? csr_wr_data : gain_ff;
      raw_in         = raw_ff;
      quot_in        = quot_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      neg_in         = neg_ff;
      rsp_error_in   = rsp_error_ff;
      rsp_bits_in    = rsp_bits_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (cmd.accept) begin
         case (pos_ff)
            POS_HEADER: begin
               header_hold_in = req_rx_byte;
               pos_in         = POS_DATA;
            end
            POS_DATA: begin
               sensor_hold_in = req_rx_byte;
               pos_in         = POS_TRAIL;
            end
            default: begin
               pos_in = POS_HEADER;
            end
         endcase
      end

      if (cmd.load) begin
         raw_in     = lookup.hit ? lookup.value : 5'sd0;
         quot_in    = sum_abs[4:0];
         rem_in     = '0;
         divisor_in = cnt_w;
         neg_in     = sum_w[5];
      end

      // one restoring step per cycle, quotient shifts in from the right
      if (cmd.div_step) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in  = 3'(trial - {1'b0, divisor_ff});
            quot_in = {quot_ff[3:0], 1'b1};
         end else begin
            rem_in  = trial[2:0];
            quot_in = {quot_ff[3:0], 1'b0};
         end
      end

      if (cmd.fix) begin
         raw_in = neg_ff ? $signed(5'(-quot_ff)) : $signed(quot_ff);
      end

      if (cmd.mul) begin
         rsp_error_in = product;
         rsp_bits_in  = sensor_hold_ff;
         rsp_valid_in = 1'b1;
      end
   end

   assign status.last_byte = pos_ff[1];
   assign status.frame_ok  = (header_hold_ff == FRAME_HEADER)
                             && (req_rx_byte == FRAME_TRAILER);
   assign status.div_skip  = lookup.hit || (cnt_w == 3'd0) || (cnt_w >= 3'd6);
   assign status.rsp_full  = rsp_valid_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_error = rsp_error_ff;
   assign rsp_line_bits      = rsp_bits_ff;

endmodule
